FILE: design/ucdp_pkg.sv
// Shared constants and types for the USB configuration descriptor parser.
package ucdp_pkg;

    localparam int MaxEndpoints = 16;
    localparam int CountW       = $clog2(MaxEndpoints + 1);

    localparam logic [7:0] DescInterface = 8'd4;
    localparam logic [7:0] DescEndpoint  = 8'd5;

    localparam logic [7:0] IntfMinLength = 8'd9;
    localparam logic [7:0] EpMinLength   = 8'd7;
    localparam logic [7:0] IntfFieldBase = 8'd5;
    localparam logic [7:0] OtherFieldBase = 8'd2;

    localparam int NumFields = 5;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    localparam logic KindEndpoint = 1'b0;
    localparam logic KindSummary  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  endpoint_slot;
        logic [3:0]  endpoint_number;
        logic        direction_in;
        logic [1:0]  xfer_type;
        logic [10:0] pkt_size;
        logic [7:0]  poll_interval;
        logic [7:0]  iface_class;
        logic [7:0]  iface_subclass;
        logic [7:0]  iface_protocol;
        logic [4:0]  endpoint_total;
        logic        last_result;
    } t_result;

endpackage

FILE: design/usb_config_descriptor_parser.sv
// Top level: USB configuration descriptor parser with a small result queue.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata=data_byte, tlast=final_byte
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata=record, tuser=kind,
//           |     |                              | tlast=last_result
//
// Each byte is parsed in the cycle it is accepted; its records land in a
// 4-entry result queue and appear on m_axis from the next cycle on.
// One byte per cycle is taken while the queue has room for two records;
// with the output side stalled the input stops once three records wait.
// A final byte with a completing endpoint descriptor pushes two records.
// Reset (i_rst_n low, synchronous) clears parser state and empties the queue.
module usb_config_descriptor_parser
    import ucdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] endpoint_slot, [7:4] endpoint_number, [8] direction_in,
    // [10:9] xfer_type, [21:11] pkt_size, [29:22] poll_interval,
    // [37:30] iface_class, [45:38] iface_subclass, [53:46] iface_protocol,
    // [58:54] endpoint_total, [63:59] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_result
);

    // Parser state
    logic [7:0]        r_offset,   n_offset;
    logic [7:0]        r_length,   n_length;
    logic [7:0]        r_type,     n_type;
    logic              r_halted,   n_halted;
    logic [7:0]        r_fields [NumFields];
    logic [7:0]        n_fields [NumFields];
    logic [23:0]       r_captured, n_captured;
    logic [CountW-1:0] r_ep_count, n_ep_count;

    // Result queue
    t_result           r_fifo [FifoDepth];
    logic [FifoAw-1:0] r_wr_ptr, r_rd_ptr;
    logic [FifoAw:0]   r_fill,   n_fill;

    logic       in_beat, out_beat;
    t_result    first_rec, second_rec;
    logic [1:0] push_n;
    t_result    head;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_fill <= (FifoAw+1)'(FifoDepth - 2));
    assign m_axis_tvalid = (r_fill != '0);

    always_comb begin
        logic [7:0]        v_type;
        logic [7:0]        v_base;
        logic [7:0]        v_f [NumFields];
        logic              v_ep;
        t_result           v_ep_rec;
        t_result           v_sum;
        logic [31:0]       v_cnt;

        n_offset   = r_offset;
        n_length   = r_length;
        n_type     = r_type;
        n_halted   = r_halted;
        n_captured = r_captured;
        n_ep_count = r_ep_count;
        for (int i = 0; i < NumFields; i++) begin
            n_fields[i] = r_fields[i];
            v_f[i]      = r_fields[i];
        end
        v_type   = r_type;
        v_base   = OtherFieldBase;
        v_ep     = 1'b0;
        v_ep_rec = '0;
        v_sum    = '0;
        v_cnt    = 32'(r_ep_count);

        if (!r_halted) begin
            if (r_offset == 8'd0) begin
                // length byte: below two stops the walk for this block
                if (s_axis_tdata < 8'd2) begin
                    n_halted = 1'b1;
                end else begin
                    n_length = s_axis_tdata;
                    n_offset = 8'd1;
                end
            end else begin
                if (r_offset == 8'd1) begin
                    v_type = s_axis_tdata;
                end
                n_type = v_type;
                v_base = (v_type == DescInterface) ? IntfFieldBase : OtherFieldBase;
                for (int i = 0; i < NumFields; i++) begin
                    if ({1'b0, r_offset} == {1'b0, v_base} + 9'(i)) begin
                        v_f[i] = s_axis_tdata;
                    end
                    n_fields[i] = v_f[i];
                end

                if ({1'b0, r_offset} + 9'd1 >= {1'b0, r_length}) begin
                    // descriptor complete
                    if (v_type == DescInterface && r_length >= IntfMinLength) begin
                        if (r_captured[7:0] == 8'd0) begin
                            n_captured = {v_f[2], v_f[1], v_f[0]};
                        end
                    end else if (v_type == DescEndpoint && r_length >= EpMinLength) begin
                        if (r_ep_count < CountW'(MaxEndpoints)) begin
                            v_ep                     = 1'b1;
                            v_ep_rec.kind            = KindEndpoint;
                            v_ep_rec.endpoint_slot   = v_cnt[3:0];
                            v_ep_rec.endpoint_number = v_f[0][3:0];
                            v_ep_rec.direction_in    = v_f[0][7];
                            v_ep_rec.xfer_type       = v_f[1][1:0];
                            v_ep_rec.pkt_size        = {v_f[3][2:0], v_f[2]};
                            v_ep_rec.poll_interval   = v_f[4];
                            v_ep_rec.last_result     = !s_axis_tlast;
                            n_ep_count               = r_ep_count + CountW'(1);
                        end
                    end
                    n_offset = 8'd0;
                    n_length = 8'd0;
                    n_type   = 8'd0;
                    for (int i = 0; i < NumFields; i++) begin
                        n_fields[i] = 8'd0;
                    end
                end else begin
                    n_offset = r_offset + 8'd1;
                end
            end
        end

        // summary sees the state after this byte, then everything clears
        v_cnt                = 32'(n_ep_count);
        v_sum.kind           = KindSummary;
        v_sum.iface_class    = n_captured[7:0];
        v_sum.iface_subclass = n_captured[15:8];
        v_sum.iface_protocol = n_captured[23:16];
        v_sum.endpoint_total = v_cnt[4:0];
        v_sum.last_result    = 1'b1;

        if (s_axis_tlast) begin
            n_offset   = 8'd0;
            n_length   = 8'd0;
            n_type     = 8'd0;
            n_halted   = 1'b0;
            n_captured = 24'd0;
            n_ep_count = '0;
            for (int i = 0; i < NumFields; i++) begin
                n_fields[i] = 8'd0;
            end
        end

        first_rec  = v_ep ? v_ep_rec : v_sum;
        second_rec = v_sum;
        push_n     = 2'(v_ep) + 2'(s_axis_tlast);
    end

    always_comb begin
        n_fill = r_fill;
        if (in_beat) begin
            n_fill = n_fill + (FifoAw+1)'(push_n);
        end
        if (out_beat) begin
            n_fill = n_fill - (FifoAw+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= 8'd0;
            r_length   <= 8'd0;
            r_type     <= 8'd0;
            r_halted   <= 1'b0;
            r_captured <= 24'd0;
            r_ep_count <= '0;
            for (int i = 0; i < NumFields; i++) begin
                r_fields[i] <= 8'd0;
            end
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fill     <= '0;
        end else begin
            if (in_beat) begin
                r_offset   <= n_offset;
                r_length   <= n_length;
                r_type     <= n_type;
                r_halted   <= n_halted;
                r_captured <= n_captured;
                r_ep_count <= n_ep_count;
                for (int i = 0; i < NumFields; i++) begin
                    r_fields[i] <= n_fields[i];
                end
                r_wr_ptr <= r_wr_ptr + FifoAw'(push_n);
            end
            if (out_beat) begin
                r_rd_ptr <= r_rd_ptr + FifoAw'(1);
            end
            r_fill <= n_fill;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_beat && push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_rec;
        end
        if (in_beat && push_n == 2'd2) begin
            r_fifo[r_wr_ptr + FifoAw'(1)] <= second_rec;
        end
    end

    assign head         = r_fifo[r_rd_ptr];
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_result;
    assign m_axis_tdata = {5'd0, head.endpoint_total, head.iface_protocol,
                           head.iface_subclass, head.iface_class, head.poll_interval,
                           head.pkt_size, head.xfer_type, head.direction_in,
                           head.endpoint_number, head.endpoint_slot};

    // queue never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (FifoAw+1)'(FifoDepth))
        else $error("result queue overfilled");

    // a halted parser sits at a descriptor boundary
    a_halt_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_offset == 8'd0))
        else $error("halted with descriptor in progress");

    // inside a descriptor the position stays below its length
    a_offset_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_offset != 8'd0) |-> (r_offset < r_length))
        else $error("descriptor position past length");

    // endpoint table never exceeds its limit
    a_ep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ep_count <= CountW'(MaxEndpoints))
        else $error("endpoint count over limit");

    // the final byte leaves a clean parser
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_axis_tlast) |=>
            (r_ep_count == '0 && !r_halted && r_offset == 8'd0 && r_captured == 24'd0))
        else $error("state not cleared after final byte");

endmodule
